@@ hdl/esas_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esas_pkg
// Shared types, constants and command codes for the exponential smoothing
// gain sweep: sample and error widths, lane divider constants and the
// command format that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package esas_pkg;

   // Field widths fixed by the interface.
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_STEPS = 9;
   localparam int GAIN_DEN   = GAIN_STEPS + 1;
   localparam int STEP_W     = 4;
   localparam int ERR_W      = 48;
   localparam logic [ERR_W-1:0] ERR_MAX = '1;

   // Default parameter values for the top level.
   localparam int DEF_WARMUP_LEN  = 5;
   localparam int DEF_MAX_SAMPLES = 1024;

   // Warmup sum width, wide enough for up to sixteen warmup samples.
   localparam int SUM_W = SAMPLE_W + 5;

   // Depth of the command queue between front end and back end.
   localparam int QUEUE_DEPTH = 4;

   // Lane divide-by-GAIN_DEN by reciprocal multiplication. The rounded
   // numerator magnitude stays below 2**LANE_N, and the extra LANE_S bits of
   // precision make the truncated product exact over that range.
   localparam int LANE_N = SAMPLE_W + $clog2(GAIN_DEN) + 1;
   localparam int LANE_S = LANE_N + $clog2(GAIN_DEN) + 1;
   localparam longint LANE_RECIP = ((longint'(1) << LANE_S) + GAIN_DEN - 1) / GAIN_DEN;

   // Command codes.
   typedef logic [1:0] cmd_kind_type;
   localparam cmd_kind_type CMD_ROW   = 2'd0;
   localparam cmd_kind_type CMD_SEED  = 2'd1;
   localparam cmd_kind_type CMD_SHORT = 2'd2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [ERR_W-1:0] err_type;

   // One queued command: a row to smooth, a warmup sum to seed from, or the
   // closing row of a series that ended too early.
   typedef struct packed {
      cmd_kind_type            kind;
      logic signed [SUM_W-1:0] data;
      logic                    last;
   } cmd_type;

endpackage
`default_nettype wire

@@ hdl/esas_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esas_front
// Input front end. Accepts samples, keeps the warmup buffer, running warmup
// sum and sample count, and turns each transaction into queued commands.
// When the warmup completes it holds off input and replays the buffer.
// ----------------------------------------------------------------------------
module esas_front
   import esas_pkg::*;
#(
   parameter int WARMUP_LEN  = DEF_WARMUP_LEN,
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  sample_type req_sample,
   input  logic       req_end_of_series,
   output logic       push_valid,
   output cmd_type    push_cmd,
   input  logic       queue_full
);

   localparam int CNT_LIMIT = (MAX_SAMPLES > WARMUP_LEN) ? MAX_SAMPLES : WARMUP_LEN;
   localparam int CNT_W     = $clog2(CNT_LIMIT + 1);
   localparam int IDX_W     = (WARMUP_LEN > 1) ? $clog2(WARMUP_LEN) : 1;
   localparam int FL_W      = $clog2(WARMUP_LEN + 1);

   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    flush_ff, flush_in;
   logic [FL_W-1:0]         flush_idx_ff, flush_idx_in;
   logic                    flush_last_ff, flush_last_in;
   sample_type              buf_ff [WARMUP_LEN];

   logic                    accept;
   logic                    in_warmup;
   logic                    completes;
   logic                    buf_wr;
   logic signed [SUM_W-1:0] x_ext;
   logic [IDX_W-1:0]        wr_idx;
   logic [IDX_W-1:0]        rd_idx;
   sample_type              buf_rd;

   // Handshake and classification of the incoming sample.
   assign req_stall = flush_ff || queue_full;
   assign accept    = req_valid && !req_stall;
   assign in_warmup = count_ff < CNT_W'(WARMUP_LEN);
   assign completes = in_warmup && (count_ff == CNT_W'(WARMUP_LEN - 1));
   assign x_ext     = SUM_W'(req_sample);
   assign wr_idx    = count_ff[IDX_W-1:0];
   assign rd_idx    = IDX_W'(flush_idx_ff - FL_W'(1));
   assign buf_rd    = buf_ff[rd_idx];

   // Next state of the count, warmup sum and replay sequencer.
   always_comb begin
      count_in      = count_ff;
      sum_in        = sum_ff;
      flush_in      = flush_ff;
      flush_idx_in  = flush_idx_ff;
      flush_last_in = flush_last_ff;
      buf_wr        = 1'b0;
      if (accept) begin
         if (in_warmup) begin
            buf_wr = 1'b1;
            sum_in = (count_ff == '0) ? x_ext : sum_ff + x_ext;
            count_in = req_end_of_series ? '0 : count_ff + CNT_W'(1);
            if (completes) begin
               flush_in      = 1'b1;
               flush_idx_in  = '0;
               flush_last_in = req_end_of_series;
            end
         end else if (req_end_of_series) begin
            count_in = '0;
         end else if (count_ff != CNT_W'(CNT_LIMIT)) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (flush_ff && !queue_full) begin
         if (flush_idx_ff == FL_W'(WARMUP_LEN)) begin
            flush_in = 1'b0;
         end else begin
            flush_idx_in = flush_idx_ff + FL_W'(1);
         end
      end
   end

   // Command generation: the replay has priority, since it blocks input.
   always_comb begin
      push_valid    = 1'b0;
      push_cmd.kind = CMD_ROW;
      push_cmd.data = x_ext;
      push_cmd.last = req_end_of_series;
      if (flush_ff) begin
         push_valid = !queue_full;
         if (flush_idx_ff == '0) begin
            push_cmd.kind = CMD_SEED;
            push_cmd.data = sum_ff;
            push_cmd.last = 1'b0;
         end else begin
            push_cmd.kind = CMD_ROW;
            push_cmd.data = SUM_W'(buf_rd);
            push_cmd.last = flush_last_ff && (flush_idx_ff == FL_W'(WARMUP_LEN));
         end
      end else if (accept) begin
         if (!in_warmup) begin
            push_valid = 1'b1;
         end else if (!completes && req_end_of_series) begin
            push_valid    = 1'b1;
            push_cmd.kind = CMD_SHORT;
            push_cmd.data = '0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         flush_ff      <= 1'b0;
         flush_idx_ff  <= '0;
         flush_last_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         flush_ff      <= flush_in;
         flush_idx_ff  <= flush_idx_in;
         flush_last_ff <= flush_last_in;
      end
   end

   // Warmup sum and sample buffer.
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (buf_wr) begin
         buf_ff[wr_idx] <= req_sample;
      end
   end

endmodule
`default_nettype wire

@@ hdl/esas_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esas_queue
// Short first-in first-out queue of commands between the front end and the
// back end, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module esas_queue
   import esas_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    queue_full,
   output logic    pop_valid,
   output cmd_type pop_cmd,
   input  logic    pop_ready
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             push_en;
   logic             pop_en;

   assign queue_full = (fill_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push_en    = push_valid && !queue_full;
   assign pop_en     = pop_valid && pop_ready;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push_en && !pop_en) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop_en && !push_en) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push_en) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

@@ hdl/esas_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// esas_back
// Execution back end. Seeds the nine smoothing lanes from the warmup mean,
// smooths one row per command with rounding division by reciprocal
// multiplication, accumulates saturating squared errors, searches for the
// best gain on the closing row and holds the result in an output register.
// ----------------------------------------------------------------------------
module esas_back
   import esas_pkg::*;
#(
   parameter int WARMUP_LEN = DEF_WARMUP_LEN
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   input  cmd_type                             pop_cmd,
   output logic                                pop_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [GAIN_STEPS-1:0][SAMPLE_W-1:0] rsp_smooth,
   output logic [STEP_W-1:0]                   rsp_best_gain_step,
   output logic [ERR_W-1:0]                    rsp_best_error,
   output logic                                rsp_row_last
);

   // State codes.
   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
   localparam logic [ST_W-1:0] ST_MEAN_MUL = 4'd1;
   localparam logic [ST_W-1:0] ST_MEAN_SET = 4'd2;
   localparam logic [ST_W-1:0] ST_LANE_MUL = 4'd3;
   localparam logic [ST_W-1:0] ST_LANE_Q   = 4'd4;
   localparam logic [ST_W-1:0] ST_SQ       = 4'd5;
   localparam logic [ST_W-1:0] ST_ACC      = 4'd6;
   localparam logic [ST_W-1:0] ST_SEARCH   = 4'd7;
   localparam logic [ST_W-1:0] ST_OUT      = 4'd8;

   // Lane arithmetic widths.
   localparam int LANE_P_W = LANE_N + LANE_S + 1;
   localparam int DIFF_W   = SAMPLE_W + 1;
   localparam int SQ_W     = 2 * DIFF_W;
   localparam int SRCH_W   = $clog2(GAIN_STEPS);
   localparam logic [LANE_S:0]   LANE_RCP  = (LANE_S + 1)'(LANE_RECIP);
   localparam logic [LANE_N-1:0] LANE_HALF = LANE_N'(GAIN_DEN / 2);

   // Warmup mean divider: divide by WARMUP_LEN through a reciprocal.
   localparam int MEAN_N   = SUM_W;
   localparam int MEAN_S   = MEAN_N + $clog2(WARMUP_LEN) + 1;
   localparam int MEAN_R_W = MEAN_S + 1;
   localparam int MEAN_P_W = MEAN_N + MEAN_R_W;
   localparam longint MEAN_RECIP_L = ((longint'(1) << MEAN_S) + WARMUP_LEN - 1) / WARMUP_LEN;
   localparam logic [MEAN_R_W-1:0] MEAN_RCP  = MEAN_R_W'(MEAN_RECIP_L);
   localparam logic [MEAN_N-1:0]   MEAN_HALF = MEAN_N'(WARMUP_LEN / 2);

   // Sequencer and row control.
   logic [ST_W-1:0]   state_ff, state_in;
   sample_type        x_ff, x_in;
   logic              last_ff, last_in;
   logic              short_ff, short_in;

   // Warmup mean path.
   logic [MEAN_N-1:0]   mean_abs_ff, mean_abs_in;
   logic                mean_neg_ff, mean_neg_in;
   logic [MEAN_P_W-1:0] mean_prod_ff, mean_prod_in;
   logic [SAMPLE_W:0]   mean_q;
   logic [SAMPLE_W:0]   mean_s;

   // Lane pipeline registers.
   logic [LANE_N-1:0]   num_abs_ff [GAIN_STEPS];
   logic [LANE_N-1:0]   num_abs_in [GAIN_STEPS];
   logic                num_neg_ff [GAIN_STEPS];
   logic                num_neg_in [GAIN_STEPS];
   logic [LANE_P_W-1:0] prod_ff [GAIN_STEPS];
   logic [LANE_P_W-1:0] prod_in [GAIN_STEPS];
   sample_type          prev_ff [GAIN_STEPS];
   sample_type          prev_in [GAIN_STEPS];
   logic [DIFF_W-1:0]   diff_ff [GAIN_STEPS];
   logic [DIFF_W-1:0]   diff_in [GAIN_STEPS];
   logic [SQ_W-1:0]     sq_ff [GAIN_STEPS];
   logic [SQ_W-1:0]     sq_in [GAIN_STEPS];
   err_type             err_ff [GAIN_STEPS];
   err_type             err_in [GAIN_STEPS];

   // Per-lane combinational results.
   logic signed [LANE_N:0] lane_num [GAIN_STEPS];
   sample_type             lane_s [GAIN_STEPS];
   logic [DIFF_W-1:0]      lane_ad [GAIN_STEPS];
   err_type                lane_acc [GAIN_STEPS];
   logic signed [LANE_N:0] pop_x_w;

   // Best gain search.
   logic [SRCH_W-1:0] srch_ff, srch_in;
   logic [SRCH_W-1:0] best_idx_ff, best_idx_in;
   err_type           best_err_ff, best_err_in;

   // Output register.
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [GAIN_STEPS-1:0][SAMPLE_W-1:0] rsp_smooth_ff, rsp_smooth_in;
   logic [STEP_W-1:0]                   rsp_step_ff, rsp_step_in;
   err_type                             rsp_err_ff, rsp_err_in;
   logic                                rsp_last_ff, rsp_last_in;

   assign pop_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_smooth         = rsp_smooth_ff;
   assign rsp_best_gain_step = rsp_step_ff;
   assign rsp_best_error     = rsp_err_ff;
   assign rsp_row_last       = rsp_last_ff;

   assign pop_x_w = (LANE_N + 1)'(pop_cmd.data);
   assign mean_q  = mean_prod_ff[MEAN_S +: SAMPLE_W + 1];
   assign mean_s  = mean_neg_ff ? -mean_q : mean_q;

   // Per-lane arithmetic: weighted numerator, quotient, error and its sum.
   for (genvar j = 0; j < GAIN_STEPS; j++) begin : g_lane
      localparam logic signed [LANE_N:0] K_NEW = (LANE_N + 1)'(GAIN_DEN - j - 1);
      localparam logic signed [LANE_N:0] K_OLD = (LANE_N + 1)'(j + 1);

      logic [SAMPLE_W:0]        q;
      logic [SAMPLE_W:0]        s_full;
      logic signed [SAMPLE_W:0] d;
      logic [ERR_W:0]           acc_sum;

      assign lane_num[j] = K_NEW * pop_x_w + K_OLD * (LANE_N + 1)'(prev_ff[j]);

      assign q         = prod_ff[j][LANE_S +: SAMPLE_W + 1];
      assign s_full    = num_neg_ff[j] ? -q : q;
      assign lane_s[j] = s_full[SAMPLE_W-1:0];

      // The difference of two samples always fits DIFF_W bits, so its
      // square never reaches the error saturation limit by itself.
      assign d          = DIFF_W'(x_ff) - DIFF_W'(lane_s[j]);
      assign lane_ad[j] = d[SAMPLE_W] ? DIFF_W'(-d) : DIFF_W'(d);

      assign acc_sum     = {1'b0, err_ff[j]} + (ERR_W + 1)'(sq_ff[j]);
      assign lane_acc[j] = acc_sum[ERR_W] ? ERR_MAX : acc_sum[ERR_W-1:0];
   end

   // Sequencer and datapath next state.
   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      last_in       = last_ff;
      short_in      = short_ff;
      mean_abs_in   = mean_abs_ff;
      mean_neg_in   = mean_neg_ff;
      mean_prod_in  = mean_prod_ff;
      num_abs_in    = num_abs_ff;
      num_neg_in    = num_neg_ff;
      prod_in       = prod_ff;
      prev_in       = prev_ff;
      diff_in       = diff_ff;
      sq_in         = sq_ff;
      err_in        = err_ff;
      srch_in       = srch_ff;
      best_idx_in   = best_idx_ff;
      best_err_in   = best_err_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_smooth_in = rsp_smooth_ff;
      rsp_step_in   = rsp_step_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               unique case (pop_cmd.kind)
                  CMD_SEED: begin
                     mean_neg_in = pop_cmd.data[SUM_W-1];
                     mean_abs_in = (pop_cmd.data[SUM_W-1] ? MEAN_N'(-pop_cmd.data)
                                                          : MEAN_N'(pop_cmd.data)) + MEAN_HALF;
                     state_in = ST_MEAN_MUL;
                  end
                  CMD_ROW: begin
                     x_in     = pop_cmd.data[SAMPLE_W-1:0];
                     last_in  = pop_cmd.last;
                     short_in = 1'b0;
                     for (int j = 0; j < GAIN_STEPS; j++) begin
                        num_neg_in[j] = lane_num[j][LANE_N];
                        num_abs_in[j] = (lane_num[j][LANE_N] ? LANE_N'(-lane_num[j])
                                                             : LANE_N'(lane_num[j])) + LANE_HALF;
                     end
                     state_in = ST_LANE_MUL;
                  end
                  CMD_SHORT: begin
                     last_in  = 1'b1;
                     short_in = 1'b1;
                     state_in = ST_OUT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MEAN_MUL: begin
            mean_prod_in = MEAN_P_W'(mean_abs_ff) * MEAN_P_W'(MEAN_RCP);
            state_in     = ST_MEAN_SET;
         end
         ST_MEAN_SET: begin
            // Every lane starts from the warmup mean with a fresh error sum.
            for (int j = 0; j < GAIN_STEPS; j++) begin
               prev_in[j] = mean_s[SAMPLE_W-1:0];
               err_in[j]  = '0;
            end
            state_in = ST_IDLE;
         end
         ST_LANE_MUL: begin
            for (int j = 0; j < GAIN_STEPS; j++) begin
               prod_in[j] = LANE_P_W'(num_abs_ff[j]) * LANE_P_W'(LANE_RCP);
            end
            state_in = ST_LANE_Q;
         end
         ST_LANE_Q: begin
            for (int j = 0; j < GAIN_STEPS; j++) begin
               prev_in[j] = lane_s[j];
               diff_in[j] = lane_ad[j];
            end
            state_in = ST_SQ;
         end
         ST_SQ: begin
            for (int j = 0; j < GAIN_STEPS; j++) begin
               sq_in[j] = SQ_W'(diff_ff[j]) * SQ_W'(diff_ff[j]);
            end
            state_in = ST_ACC;
         end
         ST_ACC: begin
            err_in = lane_acc;
            if (last_ff) begin
               best_idx_in = '0;
               best_err_in = lane_acc[0];
               srch_in     = SRCH_W'(1);
               state_in    = ST_SEARCH;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SEARCH: begin
            // One lane per cycle; a tie keeps the lower index.
            if (err_ff[srch_ff] < best_err_ff) begin
               best_idx_in = srch_ff;
               best_err_in = err_ff[srch_ff];
            end
            if (srch_ff == SRCH_W'(GAIN_STEPS - 1)) begin
               state_in = ST_OUT;
            end else begin
               srch_in = srch_ff + SRCH_W'(1);
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = last_ff;
               rsp_step_in  = '0;
               rsp_err_in   = '0;
               for (int j = 0; j < GAIN_STEPS; j++) begin
                  rsp_smooth_in[j] = short_ff ? '0 : prev_ff[j];
               end
               if (last_ff && !short_ff) begin
                  rsp_step_in = STEP_W'(best_idx_ff) + STEP_W'(1);
                  rsp_err_in  = best_err_ff;
               end
               // The closing row returns the lanes to their reset values.
               if (last_ff) begin
                  for (int j = 0; j < GAIN_STEPS; j++) begin
                     prev_in[j] = '0;
                     err_in[j]  = '0;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and lane state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < GAIN_STEPS; j++) begin
            prev_ff[j] <= '0;
            err_ff[j]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         err_ff       <= err_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      last_ff       <= last_in;
      short_ff      <= short_in;
      mean_abs_ff   <= mean_abs_in;
      mean_neg_ff   <= mean_neg_in;
      mean_prod_ff  <= mean_prod_in;
      num_abs_ff    <= num_abs_in;
      num_neg_ff    <= num_neg_in;
      prod_ff       <= prod_in;
      diff_ff       <= diff_in;
      sq_ff         <= sq_in;
      srch_ff       <= srch_in;
      best_idx_ff   <= best_idx_in;
      best_err_ff   <= best_err_in;
      rsp_smooth_ff <= rsp_smooth_in;
      rsp_step_ff   <= rsp_step_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule
`default_nettype wire

@@ hdl/exp_smoothing_alpha_sweep.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// exp_smoothing_alpha_sweep
// Sweeps nine exponential smoothing gains (0.9 down to 0.1) over one series.
//
// The req_ channel carries one signed Q3.12 sample per transaction with an
// end-of-series flag. The rsp_ channel carries one row per sample (one zero
// row for a series shorter than WARMUP_LEN): the nine smoothed values, and
// on the closing row the best gain step and its squared error sum.
// Both channels use valid and stall. The first WARMUP_LEN samples are
// only buffered. When the last of them arrives, the front end queues the
// seed and the buffered rows and holds req_stall high meanwhile.
// The back end takes each row through numerator, reciprocal multiply,
// quotient, square, accumulate and output load; seeding computes the
// warmup mean first, and the closing row adds a lane-by-lane best gain
// search. It takes no new command until the current one is done.
// A 4-entry command queue lets input continue while the back end works.
// A stalled row stays in the output register. Reset is synchronous and
// returns the block to the start of a new series.
// ----------------------------------------------------------------------------
module exp_smoothing_alpha_sweep
   import esas_pkg::*;
#(
   parameter int WARMUP_LEN  = DEF_WARMUP_LEN,
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_end_of_series,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_smooth_a90,
   output logic signed [SAMPLE_W-1:0] rsp_smooth_a80,
   output logic signed [SAMPLE_W-1:0] rsp_smooth_a70,
   output logic signed [SAMPLE_W-1:0] rsp_smooth_a60,
   output logic signed [SAMPLE_W-1:0] rsp_smooth_a50,
   output logic signed [SAMPLE_W-1:0] rsp_smooth_a40,
   output logic signed [SAMPLE_W-1:0] rsp_smooth_a30,
   output logic signed [SAMPLE_W-1:0] rsp_smooth_a20,
   output logic signed [SAMPLE_W-1:0] rsp_smooth_a10,
   output logic [STEP_W-1:0]          rsp_best_gain_step,
   output logic [ERR_W-1:0]           rsp_best_error,
   output logic                       rsp_row_last
);

   logic                                push_valid;
   cmd_type                             push_cmd;
   logic                                queue_full;
   logic                                pop_valid;
   cmd_type                             pop_cmd;
   logic                                pop_ready;
   logic [GAIN_STEPS-1:0][SAMPLE_W-1:0] smooth_row;

   // Front end: sample intake, warmup buffer and command generation.
   esas_front #(
      .WARMUP_LEN  (WARMUP_LEN),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .req_end_of_series (req_end_of_series),
      .push_valid        (push_valid),
      .push_cmd          (push_cmd),
      .queue_full        (queue_full)
   );

   // Command queue between the two halves.
   esas_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .queue_full (queue_full),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   // Back end: smoothing lanes, error sums and output register.
   esas_back #(
      .WARMUP_LEN (WARMUP_LEN)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_cmd            (pop_cmd),
      .pop_ready          (pop_ready),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_smooth         (smooth_row),
      .rsp_best_gain_step (rsp_best_gain_step),
      .rsp_best_error     (rsp_best_error),
      .rsp_row_last       (rsp_row_last)
   );

   // Lane j carries gain step j + 1.
   assign rsp_smooth_a90 = smooth_row[0];
   assign rsp_smooth_a80 = smooth_row[1];
   assign rsp_smooth_a70 = smooth_row[2];
   assign rsp_smooth_a60 = smooth_row[3];
   assign rsp_smooth_a50 = smooth_row[4];
   assign rsp_smooth_a40 = smooth_row[5];
   assign rsp_smooth_a30 = smooth_row[6];
   assign rsp_smooth_a20 = smooth_row[7];
   assign rsp_smooth_a10 = smooth_row[8];

endmodule
`default_nettype wire
